### rtl/isef_pkg.sv
// shared types and constants of the line smoother
// no dependencies; used by isef_qmul and isef_line_smoother_top
package isef_pkg;

    localparam int LINE_MAX_DEF = 64;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int ACC_W    = 18;
    localparam int PROD_W   = ACC_W + COEF_W;
    localparam int RND_BIT  = COEF_W - 1;

    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    localparam logic [COEF_W-1:0] POLE_RST   = 16'd32768;
    localparam logic [COEF_W-1:0] CGAIN_RST  = 16'd21845;
    localparam logic [COEF_W-1:0] ACGAIN_RST = 16'd10923;

    typedef enum logic [1:0] {
        REG_POLE   = 2'd0,
        REG_CGAIN  = 2'd1,
        REG_ACGAIN = 2'd2,
        REG_NONE   = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_X,
        S_MUL_P,
        S_B_RD,
        S_B_MX,
        S_B_MP,
        S_E_RD,
        S_E_OUT
    } t_state;

    typedef enum logic [1:0] {
        MS_X_G1,
        MS_A_POLE,
        MS_X_G2,
        MS_B_POLE
    } t_mul_sel;

endpackage

### rtl/isef_qmul.sv
// shared rounding multiplier: q10.8 value times q0.16 coefficient, round half up
// depends on isef_pkg for widths
module isef_qmul (
    input  logic [isef_pkg::ACC_W-1:0]  i_v,
    input  logic [isef_pkg::COEF_W-1:0] i_g,
    output logic [isef_pkg::ACC_W-1:0]  o_p
);

    logic [isef_pkg::PROD_W-1:0] prod;
    logic [isef_pkg::PROD_W-1:0] rnd;

    assign prod = isef_pkg::PROD_W'(i_v) * isef_pkg::PROD_W'(i_g);
    assign rnd  = prod + (isef_pkg::PROD_W'(1) << isef_pkg::RND_BIT);
    // result never exceeds the accumulator range
    assign o_p  = rnd[isef_pkg::PROD_W-1:isef_pkg::COEF_W];

endmodule

### rtl/isef_line_smoother_top.sv
// top level of the isef line smoother: sequencer, line stores, config registers
// depends on isef_pkg and isef_qmul
//
// Exponential smoothing of one line of up to LINE_MAX q8.8 samples, ended by
// line_end or by filling the last slot. Each sample is loaded by accepting it,
// then making two passes through the single shared multiplier for g1*x and
// pole*A. At the line end the backward pass reads the last stored sample and
// makes two multiplier passes per stored sample, and the results then leave
// one per cycle while the output is not stalled. The input is stalled during
// the multiplier passes of each sample and, at the line end, until the line
// has been emitted; the final result may still wait in the output register
// while the next line loads. No clearing pass is needed after reset.
module isef_line_smoother_top #(
    parameter int LINE_MAX = isef_pkg::LINE_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [isef_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_line_end,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [isef_pkg::SAMPLE_W-1:0] o_smoothed,
    output logic                          o_last_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [isef_pkg::CFG_AW-1:0]   paddr,
    input  logic [isef_pkg::CFG_DW-1:0]   pwdata,
    output logic [isef_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam int AccW = isef_pkg::ACC_W;
    localparam int SumW = AccW + 1;
    localparam int SmpW = isef_pkg::SAMPLE_W;
    localparam int CoefW = isef_pkg::COEF_W;

    isef_pkg::t_state   r_state, n_state;
    isef_pkg::t_mul_sel mul_sel;
    isef_pkg::t_reg_idx cfg_idx;

    logic [CoefW-1:0] r_pole, r_cgain, r_acgain;
    logic [AW-1:0]    r_fill, r_idx, r_last;
    logic [SmpW-1:0]  r_x;
    logic             r_end;
    logic [AccW-1:0]  r_acc, r_prev_a, r_bnext;
    logic [AccW-1:0]  r_rd_a, r_rd_b;
    logic             r_out_valid;
    logic [SmpW-1:0]  r_smoothed;
    logic             r_last_out;

    logic [AccW-1:0] line_store   [LINE_MAX];
    logic [AccW-1:0] causal_store [LINE_MAX];

    logic             in_accept, cfg_wr, out_free, line_done, first_term;
    logic             line_we, causal_we, rd_en, out_load;
    logic [AW-1:0]    line_waddr, line_raddr, rd_pos;
    logic [AccW-1:0]  line_wdata;
    logic [AccW-1:0]  mul_v, mul_p;
    logic [CoefW-1:0] mul_g;
    logic [SumW-1:0]  acc_sum, out_sum;
    logic [AccW-1:0]  acc_sat;
    logic [SmpW-1:0]  out_sat;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = isef_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (cfg_idx)
            isef_pkg::REG_POLE:   prdata = isef_pkg::CFG_DW'(r_pole);
            isef_pkg::REG_CGAIN:  prdata = isef_pkg::CFG_DW'(r_cgain);
            isef_pkg::REG_ACGAIN: prdata = isef_pkg::CFG_DW'(r_acgain);
            default:              prdata = '0;
        endcase
    end

    assign o_in_stall = (r_state != isef_pkg::S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign line_done  = r_end || (r_fill == AW'(LINE_MAX - 1));

    // shared multiplier operand selection
    always_comb begin
        case (mul_sel)
            isef_pkg::MS_X_G1: begin
                mul_v = AccW'(r_x);
                mul_g = r_cgain;
            end
            isef_pkg::MS_A_POLE: begin
                mul_v = r_prev_a;
                mul_g = r_pole;
            end
            isef_pkg::MS_X_G2: begin
                mul_v = r_rd_b;
                mul_g = r_acgain;
            end
            default: begin
                mul_v = r_bnext;
                mul_g = r_pole;
            end
        endcase
    end

    isef_qmul u_qmul (
        .i_v (mul_v),
        .i_g (mul_g),
        .o_p (mul_p)
    );

    // the recursive term is absent at the first sample of each pass
    assign first_term = ((r_state == isef_pkg::S_MUL_P) && (r_fill == '0)) ||
                        ((r_state == isef_pkg::S_B_MP) && (r_idx == r_last));
    assign acc_sum = SumW'(r_acc) + (first_term ? SumW'(0) : SumW'(mul_p));
    assign acc_sat = acc_sum[SumW-1] ? {AccW{1'b1}} : acc_sum[AccW-1:0];

    assign out_sum = SumW'(r_rd_a) + ((r_idx == r_last) ? SumW'(0) : SumW'(r_rd_b));
    assign out_sat = (|out_sum[SumW-1:SmpW]) ? {SmpW{1'b1}} : out_sum[SmpW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            isef_pkg::S_IDLE:  if (in_accept) n_state = isef_pkg::S_MUL_X;
            isef_pkg::S_MUL_X: n_state = isef_pkg::S_MUL_P;
            isef_pkg::S_MUL_P: n_state = line_done ? isef_pkg::S_B_RD : isef_pkg::S_IDLE;
            isef_pkg::S_B_RD:  n_state = isef_pkg::S_B_MX;
            isef_pkg::S_B_MX:  n_state = isef_pkg::S_B_MP;
            isef_pkg::S_B_MP:  n_state = (r_idx == '0) ? isef_pkg::S_E_RD : isef_pkg::S_B_MX;
            isef_pkg::S_E_RD:  n_state = isef_pkg::S_E_OUT;
            isef_pkg::S_E_OUT: begin
                if (out_free && (r_idx == r_last)) n_state = isef_pkg::S_IDLE;
            end
            default:           n_state = isef_pkg::S_IDLE;
        endcase
    end

    // control outputs of the sequencer
    always_comb begin
        mul_sel    = isef_pkg::MS_X_G1;
        line_we    = 1'b0;
        causal_we  = 1'b0;
        rd_en      = 1'b0;
        rd_pos     = r_idx;
        line_raddr = r_idx;
        out_load   = 1'b0;
        unique case (r_state)
            isef_pkg::S_IDLE:  ;
            isef_pkg::S_MUL_X: mul_sel = isef_pkg::MS_X_G1;
            isef_pkg::S_MUL_P: begin
                mul_sel   = isef_pkg::MS_A_POLE;
                line_we   = 1'b1;
                causal_we = 1'b1;
            end
            isef_pkg::S_B_RD:  rd_en = 1'b1;
            isef_pkg::S_B_MX:  mul_sel = isef_pkg::MS_X_G2;
            isef_pkg::S_B_MP: begin
                mul_sel = isef_pkg::MS_B_POLE;
                line_we = 1'b1;
                // fetch the next sample back while this one is written
                if (r_idx != '0) begin
                    rd_en      = 1'b1;
                    line_raddr = r_idx - AW'(1);
                end
            end
            isef_pkg::S_E_RD: begin
                rd_en      = 1'b1;
                line_raddr = r_idx + AW'(1);
            end
            isef_pkg::S_E_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_idx != r_last) begin
                        rd_en      = 1'b1;
                        rd_pos     = r_idx + AW'(1);
                        line_raddr = r_idx + AW'(2);
                    end
                end
            end
            default: ;
        endcase
    end

    // the line store holds samples, then the backward values in their place
    assign line_waddr = (r_state == isef_pkg::S_MUL_P) ? r_fill : r_idx;
    assign line_wdata = (r_state == isef_pkg::S_MUL_P) ? AccW'(r_x) : acc_sat;

    always_ff @(posedge i_clk) begin
        if (line_we) begin
            line_store[line_waddr] <= line_wdata;
        end
        if (causal_we) begin
            causal_store[r_fill] <= acc_sat;
        end
        if (rd_en) begin
            r_rd_a <= causal_store[rd_pos];
            r_rd_b <= line_store[line_raddr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= isef_pkg::S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_pole      <= isef_pkg::POLE_RST;
            r_cgain     <= isef_pkg::CGAIN_RST;
            r_acgain    <= isef_pkg::ACGAIN_RST;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                case (cfg_idx)
                    isef_pkg::REG_POLE:   r_pole   <= pwdata[CoefW-1:0];
                    isef_pkg::REG_CGAIN:  r_cgain  <= pwdata[CoefW-1:0];
                    isef_pkg::REG_ACGAIN: r_acgain <= pwdata[CoefW-1:0];
                    default: ;
                endcase
            end
            if (r_state == isef_pkg::S_MUL_P) begin
                r_fill <= line_done ? '0 : r_fill + AW'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_x   <= i_sample;
            r_end <= i_line_end;
        end
        if ((r_state == isef_pkg::S_MUL_X) || (r_state == isef_pkg::S_B_MX)) begin
            r_acc <= mul_p;
        end
        if (r_state == isef_pkg::S_MUL_P) begin
            r_prev_a <= acc_sat;
            if (line_done) begin
                r_last <= r_fill;
                r_idx  <= r_fill;
            end
        end
        if (r_state == isef_pkg::S_B_MP) begin
            r_bnext <= acc_sat;
            if (r_idx != '0) r_idx <= r_idx - AW'(1);
        end
        if (out_load) begin
            r_smoothed <= out_sat;
            r_last_out <= (r_idx == r_last);
            if (r_idx != r_last) r_idx <= r_idx + AW'(1);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_smoothed  = r_smoothed;
    assign o_last_out  = r_last_out;

`ifndef SYNTHESIS
    // leaving the emit phase leaves the final item of the line in the output register
    a_last_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == isef_pkg::S_E_OUT && n_state == isef_pkg::S_IDLE)
        |=> (r_out_valid && r_last_out))
        else $error("line left emit without a final item");

    // the fill count is back at zero once the backward pass is under way
    a_fill_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == isef_pkg::S_B_MX) |-> (r_fill == '0))
        else $error("fill count not cleared at line end");

    // emission never runs past the stored line
    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == isef_pkg::S_E_OUT) |-> (r_idx <= r_last))
        else $error("emit index beyond line length");
`endif

endmodule
